/* hdl/bmd_pkg.sv */
`default_nettype none
package bmd_pkg;

    localparam int PIX_W      = 8;
    localparam int WIDTH_W    = 12;
    localparam int HEIGHT_W   = 16;
    localparam int ROW_W      = 17;
    localparam int SUM_W      = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 4'd1;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 12'd390;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd300;

    // bayer site of the output pixel, grbg mosaic
    typedef enum logic [1:0] {
        SITE_GR = 2'd0,
        SITE_R  = 2'd1,
        SITE_B  = 2'd2,
        SITE_GB = 2'd3
    } t_site;

    typedef logic [24:0][PIX_W-1:0] t_patch;
    typedef logic signed [SUM_W-1:0] t_sum;

    typedef struct packed {
        t_patch patch;
        t_site  site;
        logic   eor;
        logic   eof;
    } t_item;

    function automatic t_sum px(input t_patch p, input int unsigned i);
        return $signed({8'd0, p[i]});
    endfunction

    // kernels held times two
    function automatic t_sum k_cross(input t_patch p);
        return t_sum'(4 * (px(p, 7) + px(p, 11) + px(p, 13) + px(p, 17))
                    - 2 * (px(p, 2) + px(p, 10) + px(p, 14) + px(p, 22))
                    + 8 * px(p, 12));
    endfunction

    function automatic t_sum k_horiz(input t_patch p);
        return t_sum'((px(p, 2) + px(p, 22))
                    - 2 * (px(p, 6) + px(p, 8) + px(p, 16) + px(p, 18)
                           + px(p, 10) + px(p, 14))
                    + 8 * (px(p, 11) + px(p, 13)) + 10 * px(p, 12));
    endfunction

    function automatic t_sum k_vert(input t_patch p);
        return t_sum'((px(p, 10) + px(p, 14))
                    - 2 * (px(p, 6) + px(p, 8) + px(p, 16) + px(p, 18)
                           + px(p, 2) + px(p, 22))
                    + 8 * (px(p, 7) + px(p, 17)) + 10 * px(p, 12));
    endfunction

    function automatic t_sum k_diag(input t_patch p);
        return t_sum'(4 * (px(p, 6) + px(p, 8) + px(p, 16) + px(p, 18))
                    - 3 * (px(p, 2) + px(p, 10) + px(p, 14) + px(p, 22))
                    + 12 * px(p, 12));
    endfunction

    // divide by 16 toward zero, then clamp to 0..255
    function automatic logic [PIX_W-1:0] clamp(input t_sum s);
        logic [PIX_W-1:0] res;
        if (s < 0) begin
            res = '0;
        end else if (s[SUM_W-1:12] != '0) begin
            res = 8'hff;
        end else begin
            res = s[11:4];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

/* hdl/bmd_intf.sv */
`default_nettype none
interface bmd_pix_if;
    logic                      valid;
    logic                      ready;
    logic [bmd_pkg::PIX_W-1:0] raw_pixel;
    logic                      flush;
    modport source (output valid, output raw_pixel, output flush, input ready);
    modport sink   (input valid, input raw_pixel, input flush, output ready);
endinterface

interface bmd_rgb_if;
    logic                      valid;
    logic                      ready;
    logic [bmd_pkg::PIX_W-1:0] red;
    logic [bmd_pkg::PIX_W-1:0] green;
    logic [bmd_pkg::PIX_W-1:0] blue;
    logic                      end_of_row;
    logic                      end_of_frame;
    modport source (output valid, output red, output green, output blue,
                    output end_of_row, output end_of_frame, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input end_of_row, input end_of_frame, output ready);
endinterface

interface bmd_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [bmd_pkg::CFG_IDX_W-1:0]  index;
    logic [bmd_pkg::CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* hdl/bmd_front.sv */
`default_nettype none
module bmd_front #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    bmd_pix_if.sink             i_pix,
    bmd_cfg_if.sink             i_cfg,
    input  wire logic           i_q_ready,
    output logic                o_q_push,
    output bmd_pkg::t_item      o_q_item
);

    localparam int XW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int CW = (WW > bmd_pkg::WIDTH_W) ? WW : bmd_pkg::WIDTH_W;
    localparam int RW = bmd_pkg::ROW_W;

    logic [bmd_pkg::WIDTH_W-1:0]  r_width;
    logic [bmd_pkg::HEIGHT_W-1:0] r_height;
    logic [XW-1:0]                r_x;
    logic [RW-1:0]                r_y;

    logic                         r_s1_v;
    logic                         r_s1_out;
    logic [bmd_pkg::PIX_W-1:0]    r_s1_new;
    logic [1:0]                   r_s1_yl;
    logic [4:0][2:0]              r_s1_rsel;
    logic [4:0][2:0]              r_s1_csel;
    bmd_pkg::t_site               r_s1_site;
    logic                         r_s1_eor;
    logic                         r_s1_eof;

    logic [bmd_pkg::PIX_W-1:0]    r_win [5][5];
    logic [bmd_pkg::PIX_W-1:0]    n_win [5][5];
    logic [bmd_pkg::PIX_W-1:0]    rd [4];
    logic [bmd_pkg::PIX_W-1:0]    v [5];

    logic [CW-1:0]                cfg_w;
    logic [WW-1:0]                w_eff;
    logic [bmd_pkg::HEIGHT_W-1:0] h_eff;
    logic [RW-1:0]                h_ext;
    logic [WW-1:0]                x_ext;
    logic                         x_wrap;
    logic                         col_hi;
    logic [WW:0]                  c_full;
    logic [WW-1:0]                c;
    logic [RW-1:0]                rv;
    logic                         r_ok;
    logic                         eor;
    logic                         eof;
    logic                         drain;
    logic                         ignore;
    logic                         accept;
    logic                         take;
    logic                         s1_fire;
    logic                         cfg_wr;
    bmd_pkg::t_site               site;
    bmd_pkg::t_patch              patch;

    // window slot for each tap of a 5-tap line mirrored about the edge
    function automatic logic [4:0][2:0] mir_sel(input logic a0, input logic a1,
                                               input logic al, input logic al2);
        logic [4:0][2:0] s;
        s[0] = a0 ? 3'd4 : (a1 ? 3'd2 : 3'd0);
        s[1] = a0 ? 3'd3 : 3'd1;
        s[2] = 3'd2;
        s[3] = al ? 3'd1 : 3'd3;
        s[4] = al ? 3'd0 : (al2 ? 3'd2 : 3'd4);
        return s;
    endfunction

    assign cfg_w = CW'(r_width);
    assign w_eff = (cfg_w < CW'(3)) ? WW'(3) :
                   (cfg_w > CW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(cfg_w);
    assign h_eff = (r_height < 16'd3) ? 16'd3 : r_height;
    assign h_ext = RW'(h_eff);

    assign x_ext  = WW'(r_x);
    assign x_wrap = ({1'b0, x_ext} + (WW+1)'(1)) >= {1'b0, w_eff};
    assign col_hi = x_ext >= WW'(2);
    assign c_full = col_hi ? ({1'b0, x_ext} - (WW+1)'(2))
                           : ({1'b0, x_ext} + {1'b0, w_eff} - (WW+1)'(2));
    assign c      = c_full[WW-1:0];
    assign rv     = col_hi ? (r_y - RW'(2)) : (r_y - RW'(3));
    assign r_ok   = (col_hi ? (r_y >= RW'(2)) : (r_y >= RW'(3))) && (rv < h_ext);
    // the last column of a row comes out when the next row's second pixel goes in
    assign eor    = !col_hi && (x_ext == WW'(1));
    assign eof    = eor && (rv == h_ext - RW'(1));

    assign drain  = r_y >= h_ext;
    assign ignore = i_pix.flush && !drain;

    assign s1_fire     = r_s1_v && (i_q_ready || !r_s1_out);
    assign i_pix.ready = !r_s1_v || s1_fire;
    assign accept      = i_pix.valid && i_pix.ready;
    assign take        = accept && !ignore;

    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid && ((i_cfg.index == bmd_pkg::CFG_IMAGE_WIDTH) ||
                                         (i_cfg.index == bmd_pkg::CFG_IMAGE_HEIGHT));

    always_comb begin
        case ({rv[0], c[0]})
            2'b00:   site = bmd_pkg::SITE_GR;
            2'b01:   site = bmd_pkg::SITE_R;
            2'b10:   site = bmd_pkg::SITE_B;
            default: site = bmd_pkg::SITE_GB;
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < 4; g++) begin : g_line
            logic [bmd_pkg::PIX_W-1:0] r_mem [MAX_WIDTH];
            logic [bmd_pkg::PIX_W-1:0] r_rd;
            always_ff @(posedge i_clk) begin
                if (take) begin
                    r_rd <= r_mem[r_x];
                    if (!drain && (r_y[1:0] == 2'(g))) begin
                        r_mem[r_x] <= i_pix.raw_pixel;
                    end
                end
            end
            assign rd[g] = r_rd;
        end
    endgenerate

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            v[k] = rd[2'(r_s1_yl + 2'(k))];
        end
        v[4] = r_s1_new;
        for (int k = 0; k < 5; k++) begin
            for (int l = 0; l < 4; l++) begin
                n_win[k][l] = r_win[k][l+1];
            end
            n_win[k][4] = v[k];
        end
        for (int k = 0; k < 5; k++) begin
            for (int l = 0; l < 5; l++) begin
                patch[k*5 + l] = n_win[r_s1_rsel[k]][r_s1_csel[l]];
            end
        end
    end

    assign o_q_push       = r_s1_v && r_s1_out;
    assign o_q_item.patch = patch;
    assign o_q_item.site  = r_s1_site;
    assign o_q_item.eor   = r_s1_eor;
    assign o_q_item.eof   = r_s1_eof;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= bmd_pkg::WIDTH_RESET;
            r_height <= bmd_pkg::HEIGHT_RESET;
            r_x      <= '0;
            r_y      <= '0;
            r_s1_v   <= 1'b0;
        end else begin
            if (cfg_wr) begin
                if (i_cfg.index == bmd_pkg::CFG_IMAGE_WIDTH) begin
                    r_width <= i_cfg.data[bmd_pkg::WIDTH_W-1:0];
                end else begin
                    r_height <= i_cfg.data;
                end
                r_x <= '0;
                r_y <= '0;
            end else if (take) begin
                if (eof) begin
                    r_x <= '0;
                    r_y <= '0;
                end else if (x_wrap) begin
                    r_x <= '0;
                    r_y <= r_y + RW'(1);
                end else begin
                    r_x <= r_x + XW'(1);
                end
            end
            if (take) begin
                r_s1_v <= 1'b1;
            end else if (s1_fire) begin
                r_s1_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s1_out  <= r_ok;
            r_s1_new  <= drain ? '0 : i_pix.raw_pixel;
            r_s1_yl   <= r_y[1:0];
            r_s1_rsel <= mir_sel(rv == '0, rv == RW'(1), rv == h_ext - RW'(1),
                                 rv == h_ext - RW'(2));
            r_s1_csel <= mir_sel(c == '0, c == WW'(1), c == w_eff - WW'(1),
                                 c == w_eff - WW'(2));
            r_s1_site <= site;
            r_s1_eor  <= eor;
            r_s1_eof  <= eof;
        end
        if (s1_fire) begin
            r_win <= n_win;
        end
    end

endmodule
`default_nettype wire

/* hdl/bmd_queue.sv */
`default_nettype none
module bmd_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire bmd_pkg::t_item  i_item,
    output logic                 o_ready,
    output logic                 o_valid,
    output bmd_pkg::t_item       o_item,
    input  wire logic            i_pop
);

    bmd_pkg::t_item r_buf [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           do_push;
    logic           do_pop;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_item  = r_buf[r_rp];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_buf[r_wp] <= i_item;
        end
    end

endmodule
`default_nettype wire

/* hdl/bmd_back.sv */
`default_nettype none
module bmd_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire bmd_pkg::t_item  i_item,
    output logic                 o_pop,
    bmd_rgb_if.source            o_rgb
);

    logic                      r_a_v;
    bmd_pkg::t_sum             r_a_cross;
    bmd_pkg::t_sum             r_a_horiz;
    bmd_pkg::t_sum             r_a_vert;
    bmd_pkg::t_sum             r_a_diag;
    logic [bmd_pkg::PIX_W-1:0] r_a_ctr;
    bmd_pkg::t_site            r_a_site;
    logic                      r_a_eor;
    logic                      r_a_eof;

    logic                      r_b_v;
    logic [bmd_pkg::PIX_W-1:0] r_b_red;
    logic [bmd_pkg::PIX_W-1:0] r_b_green;
    logic [bmd_pkg::PIX_W-1:0] r_b_blue;
    logic                      r_b_eor;
    logic                      r_b_eof;

    logic [bmd_pkg::PIX_W-1:0] n_red;
    logic [bmd_pkg::PIX_W-1:0] n_green;
    logic [bmd_pkg::PIX_W-1:0] n_blue;
    logic                      b_ready;
    logic                      a_ready;
    logic                      a_move;

    assign b_ready = !r_b_v || o_rgb.ready;
    assign a_ready = !r_a_v || b_ready;
    assign o_pop   = i_valid && a_ready;
    assign a_move  = r_a_v && b_ready;

    always_comb begin
        case (r_a_site)
            bmd_pkg::SITE_GR: begin
                n_red   = bmd_pkg::clamp(r_a_horiz);
                n_green = r_a_ctr;
                n_blue  = bmd_pkg::clamp(r_a_vert);
            end
            bmd_pkg::SITE_R: begin
                n_red   = r_a_ctr;
                n_green = bmd_pkg::clamp(r_a_cross);
                n_blue  = bmd_pkg::clamp(r_a_diag);
            end
            bmd_pkg::SITE_B: begin
                n_red   = bmd_pkg::clamp(r_a_diag);
                n_green = bmd_pkg::clamp(r_a_cross);
                n_blue  = r_a_ctr;
            end
            default: begin
                n_red   = bmd_pkg::clamp(r_a_vert);
                n_green = r_a_ctr;
                n_blue  = bmd_pkg::clamp(r_a_horiz);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_v <= i_valid;
            end
            if (b_ready) begin
                r_b_v <= r_a_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_a_cross <= bmd_pkg::k_cross(i_item.patch);
            r_a_horiz <= bmd_pkg::k_horiz(i_item.patch);
            r_a_vert  <= bmd_pkg::k_vert(i_item.patch);
            r_a_diag  <= bmd_pkg::k_diag(i_item.patch);
            r_a_ctr   <= i_item.patch[12];
            r_a_site  <= i_item.site;
            r_a_eor   <= i_item.eor;
            r_a_eof   <= i_item.eof;
        end
        if (a_move) begin
            r_b_red   <= n_red;
            r_b_green <= n_green;
            r_b_blue  <= n_blue;
            r_b_eor   <= r_a_eor;
            r_b_eof   <= r_a_eof;
        end
    end

    assign o_rgb.valid        = r_b_v;
    assign o_rgb.red          = r_b_red;
    assign o_rgb.green        = r_b_green;
    assign o_rgb.blue         = r_b_blue;
    assign o_rgb.end_of_row   = r_b_eor;
    assign o_rgb.end_of_frame = r_b_eof;

endmodule
`default_nettype wire

/* hdl/bayer_mhc_demosaic.sv */
// channel   dir   word
// i_pix     in    raw_pixel[7:0], flush
// o_rgb     out   red[7:0], green[7:0], blue[7:0], end_of_row, end_of_frame
// i_cfg     in    index[3:0] (0 image_width, 1 image_height), data[15:0]
//
// one raw word per clock sustained while o_rgb is ready; a pixel is computed 2*width+2 words
// after it enters, and reaches o_rgb through the line store read and window, the queue, the
// kernel sums and the output register.
// the line store is four MAX_WIDTH x 8 memories with one registered read port each.
// synchronous active-low reset clears counters and handshake state; the line store
// keeps its contents, rows outside the image are mirrored away and never reach an output.
// a two-word queue splits front and back so each side stalls on its own.
`default_nettype none
module bayer_mhc_demosaic #(
    parameter int MAX_WIDTH = 2048
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bmd_pix_if.sink    i_pix,
    bmd_rgb_if.source  o_rgb,
    bmd_cfg_if.sink    i_cfg
);

    logic           q_push;
    logic           q_ready;
    logic           q_valid;
    logic           q_pop;
    bmd_pkg::t_item f_item;
    bmd_pkg::t_item q_item;

    bmd_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_pix     (i_pix),
        .i_cfg     (i_cfg),
        .i_q_ready (q_ready),
        .o_q_push  (q_push),
        .o_q_item  (f_item)
    );

    bmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (f_item),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    bmd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_item  (q_item),
        .o_pop   (q_pop),
        .o_rgb   (o_rgb)
    );

endmodule
`default_nettype wire

/* hdl/bmd_checker.sv */
`default_nettype none
module bmd_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_cfg_ready,
    input wire logic       i_out_valid,
    input wire logic       i_out_ready,
    input wire logic [7:0] i_out_red,
    input wire logic [7:0] i_out_green,
    input wire logic [7:0] i_out_blue,
    input wire logic       i_out_eor,
    input wire logic       i_out_eof
);

    // frame end is always a row end
    a_eof_eor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (!i_out_eof || i_out_eor))
        else $error("end_of_frame without end_of_row");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> i_cfg_ready)
        else $error("config port not ready");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output word right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_red)
            && $stable(i_out_green) && $stable(i_out_blue)
            && $stable(i_out_eor) && $stable(i_out_eof)))
        else $error("stalled output word changed");

endmodule

bind bayer_mhc_demosaic bmd_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_ready (i_cfg.ready),
    .i_out_valid (o_rgb.valid),
    .i_out_ready (o_rgb.ready),
    .i_out_red   (o_rgb.red),
    .i_out_green (o_rgb.green),
    .i_out_blue  (o_rgb.blue),
    .i_out_eor   (o_rgb.end_of_row),
    .i_out_eof   (o_rgb.end_of_frame)
);
`default_nettype wire
